/* hdl/pfba_pkg.sv */
// page frame bitmap allocator: shared constants, codes and types
// no dependencies; used by pfba_map_ram and page_frame_bitmap_allocator
`default_nettype none

package pfba_pkg;

  localparam int unsigned MaxPages = 65536;
  localparam int unsigned WordBits = 64;
  localparam int unsigned MapWords = MaxPages / WordBits;
  localparam int unsigned WordAw   = $clog2(MapWords);
  localparam int unsigned BitAw    = $clog2(WordBits);
  localparam int unsigned PageW    = 16;
  localparam int unsigned CountW   = 17;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned StatusW  = 2;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [WordAw-1:0]   waddr_t;
  typedef logic [BitAw-1:0]    bidx_t;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_MARK  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_OOM   = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic   we;
    waddr_t waddr;
    word_t  wdata;
    waddr_t raddr;
  } ram_req_t;

  function automatic bidx_t lowest_set(input word_t w);
    bidx_t idx;
    idx = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = bidx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* hdl/pfba_map_ram.sv */
// used/free map storage: one write port, one read port, registered read data
// depends on pfba_pkg
`default_nettype none

module pfba_map_ram (
  input  wire logic               clk_i,
  input  wire pfba_pkg::ram_req_t req_i,
  output pfba_pkg::word_t         rdata_o
);
  import pfba_pkg::*;

  word_t mem [MapWords];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/page_frame_bitmap_allocator.sv */
// first-fit page frame allocator over a 1024 x 64 used/free map
// depends on pfba_pkg and pfba_map_ram
//
// channel   | signals                               | transaction
// ----------+---------------------------------------+------------------------------
// request   | start, busy, mode_i, page_number_i    | start high while busy low
// result    | done_o, page_number_out_o, status_o   | done_o high for one cycle
// config    | page_count_we_i, page_count_i         | page_count_we_i high
//
// after reset a clearing pass sets every map word to used, with busy high
// allocate: the scan reads map words from word 0 up to the last word the page count reaches (1..1024 words),
// one word per cycle through the map read port; done_o is registered after the first free bit or the last word
// free and mark: read-modify-write of one word, written back in ST_RMW, done_o registered from that state
// rejected requests and no-ops: done_o in the cycle after the transaction
// the receiver cannot stall; one request is in work at a time
`default_nettype none

module page_frame_bitmap_allocator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pfba_pkg::ModeW-1:0]    mode_i,
  input  wire logic [pfba_pkg::PageW-1:0]    page_number_i,
  input  wire logic                          page_count_we_i,
  input  wire logic [pfba_pkg::CountW-1:0]   page_count_i,
  output logic                               done_o,
  output logic [pfba_pkg::PageW-1:0]         page_number_out_o,
  output logic [pfba_pkg::StatusW-1:0]       status_o
);
  import pfba_pkg::*;

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_RMW  = 2'd3;

  logic [1:0]        state_q, state_d;
  waddr_t            init_addr_q, init_addr_d;
  waddr_t            scan_addr_q, scan_addr_d;
  mode_e             mode_q, mode_d;
  logic [PageW-1:0]  pn_q, pn_d;
  logic              done_q, done_d;
  logic [PageW-1:0]  page_out_q, page_out_d;
  status_e           status_q, status_d;
  logic [CountW-1:0] page_count_q;

  ram_req_t          ram_req;
  word_t             rdata;

  logic [CountW-1:0] lim;
  waddr_t            last_word;
  bidx_t             tail;
  word_t             tail_mask;
  word_t             free_bits;
  logic              hit;
  bidx_t             hit_bit;
  word_t             pn_bit;

  pfba_map_ram u_map_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  // effective page count and the last word it reaches
  assign lim       = (page_count_q > CountW'(MaxPages)) ? CountW'(MaxPages) : page_count_q;
  assign last_word = WordAw'((lim - CountW'(1)) >> BitAw);
  assign tail      = lim[BitAw-1:0];

  always_comb begin
    if ((tail == '0) || (scan_addr_q != last_word)) begin
      tail_mask = '1;
    end else begin
      tail_mask = (word_t'(1) << tail) - word_t'(1);
    end
  end

  assign free_bits = ~rdata & tail_mask;
  assign hit       = |free_bits;
  assign hit_bit   = lowest_set(free_bits);
  assign pn_bit    = word_t'(1) << pn_q[BitAw-1:0];

  always_comb begin
    state_d       = state_q;
    init_addr_d   = init_addr_q;
    scan_addr_d   = scan_addr_q;
    mode_d        = mode_q;
    pn_d          = pn_q;
    done_d        = 1'b0;
    page_out_d    = page_out_q;
    status_d      = status_q;
    ram_req.we    = 1'b0;
    ram_req.waddr = scan_addr_q;
    ram_req.wdata = rdata;
    ram_req.raddr = '0;

    unique case (state_q)
      ST_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = init_addr_q;
        ram_req.wdata = '1;
        init_addr_d   = init_addr_q + WordAw'(1);
        if (init_addr_q == WordAw'(MapWords - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_req.raddr = page_number_i[PageW-1:BitAw];
        if (start) begin
          mode_d = mode_e'(mode_i);
          pn_d   = page_number_i;
          unique case (mode_e'(mode_i)) inside
            MODE_ALLOC: begin
              ram_req.raddr = '0;
              if (lim == '0) begin
                done_d     = 1'b1;
                page_out_d = '0;
                status_d   = STATUS_OOM;
              end else begin
                scan_addr_d = '0;
                state_d     = ST_SCAN;
              end
            end
            MODE_FREE, MODE_MARK: begin
              if (CountW'(page_number_i) >= lim) begin
                done_d     = 1'b1;
                page_out_d = '0;
                status_d   = STATUS_RANGE;
              end else begin
                state_d = ST_RMW;
              end
            end
            default: begin
              done_d     = 1'b1;
              page_out_d = '0;
              status_d   = STATUS_OK;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ram_req.raddr = scan_addr_q + WordAw'(1);
        if (hit) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = scan_addr_q;
          ram_req.wdata = rdata | (word_t'(1) << hit_bit);
          done_d        = 1'b1;
          page_out_d    = PageW'({scan_addr_q, hit_bit});
          status_d      = STATUS_OK;
          state_d       = ST_IDLE;
        end else if (scan_addr_q == last_word) begin
          done_d     = 1'b1;
          page_out_d = '0;
          status_d   = STATUS_OOM;
          state_d    = ST_IDLE;
        end else begin
          scan_addr_d = scan_addr_q + WordAw'(1);
        end
      end
      ST_RMW: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pn_q[PageW-1:BitAw];
        ram_req.wdata = (mode_q == MODE_FREE) ? (rdata & ~pn_bit) : (rdata | pn_bit);
        done_d        = 1'b1;
        page_out_d    = '0;
        status_d      = STATUS_OK;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      init_addr_q  <= '0;
      done_q       <= 1'b0;
      page_count_q <= CountW'(MaxPages);
    end else begin
      state_q     <= state_d;
      init_addr_q <= init_addr_d;
      done_q      <= done_d;
      if (page_count_we_i) begin
        page_count_q <= page_count_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    scan_addr_q <= scan_addr_d;
    mode_q      <= mode_d;
    pn_q        <= pn_d;
    page_out_q  <= page_out_d;
    status_q    <= status_d;
  end

  assign busy              = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign page_number_out_o = page_out_q;
  assign status_o          = status_q;

endmodule

`default_nettype wire
